// ===== src/armdp_pkg.sv =====
// Shared types and constants for the ARM data-processing execute block.
package armdp_pkg;

  // Instruction form carried in the input item's tuser
  typedef enum logic [1:0] {
    CMD_REG = 2'd0,   // register operand, immediate shift
    CMD_IMM = 2'd1,   // rotated immediate
    CMD_RSR = 2'd2    // register-shifted register
  } cmd_t;

  // Supported data-processing opcodes, instruction bits 24:21
  typedef enum logic [3:0] {
    OP_AND = 4'd0,
    OP_EOR = 4'd1,
    OP_SUB = 4'd2,
    OP_ADD = 4'd4,
    OP_CMP = 4'd10,
    OP_MOV = 4'd13,
    OP_BIC = 4'd14,
    OP_MVN = 4'd15
  } op_t;

  // Shifter operation; the first four match the instruction's type field
  typedef enum logic [2:0] {
    SH_LSL = 3'd0,
    SH_LSR = 3'd1,
    SH_ASR = 3'd2,
    SH_ROR = 3'd3,
    SH_RRX = 3'd4
  } shift_t;

  localparam int unsigned XLEN     = 32;
  localparam int unsigned NREGS    = 16;
  localparam logic [3:0]  PC_INDEX = 4'd15;
  localparam logic [7:0]  IMM8_MASK = 8'hff;

  // Flag bit positions within NZCV
  localparam int unsigned FLAG_N = 3;
  localparam int unsigned FLAG_Z = 2;
  localparam int unsigned FLAG_C = 1;
  localparam int unsigned FLAG_V = 0;

  // Execute result handed from the ALU to the top level
  typedef struct packed {
    logic             wr;
    logic             unsup;
    logic [XLEN-1:0]  res;
    logic [3:0]       flags;
  } alu_res_t;

endpackage

// ===== src/armdp_shifter.sv =====
// Barrel shifter with ARM shifter carry-out, used for all operand-2 forms.
module armdp_shifter (
  input  logic [armdp_pkg::XLEN-1:0] value,
  input  armdp_pkg::shift_t          kind,
  input  logic [7:0]                 amt,
  input  logic                       cin,
  output logic [armdp_pkg::XLEN-1:0] res,
  output logic                       cout
);

  logic [5:0]         amt_sat;
  logic               big;
  logic [32:0]        lsl_t;
  logic [32:0]        lsr_t;
  logic signed [32:0] asr_t;
  logic [63:0]        ror_t;

  assign big     = amt > 8'd32;
  assign amt_sat = big ? 6'd32 : amt[5:0];
  // carry falls out of the extra bit on each side
  assign lsl_t   = {1'b0, value} << amt_sat;
  assign lsr_t   = {value, 1'b0} >> amt_sat;
  assign asr_t   = $signed({value, 1'b0}) >>> amt_sat;
  assign ror_t   = {value, value} >> amt[4:0];

  always_comb begin
    res  = value;
    cout = cin;
    if (kind == armdp_pkg::SH_RRX) begin
      res  = {cin, value[31:1]};
      cout = value[0];
    end else if (amt != 8'd0) begin
      unique case (kind)
        armdp_pkg::SH_LSL: begin
          res  = big ? '0 : lsl_t[31:0];
          cout = big ? 1'b0 : lsl_t[32];
        end
        armdp_pkg::SH_LSR: begin
          res  = big ? '0 : lsr_t[32:1];
          cout = big ? 1'b0 : lsr_t[0];
        end
        armdp_pkg::SH_ASR: begin
          res  = asr_t[32:1];
          cout = asr_t[0];
        end
        armdp_pkg::SH_ROR: begin
          res  = ror_t[31:0];
          cout = ror_t[31];
        end
        default: begin
          res  = value;
          cout = cin;
        end
      endcase
    end
  end

endmodule

// ===== src/armdp_alu.sv =====
// Data-processing ALU: logical ops, add/subtract and NZCV update.
module armdp_alu (
  input  logic [armdp_pkg::XLEN-1:0] a,
  input  logic [armdp_pkg::XLEN-1:0] op2,
  input  logic                       sc,
  input  logic [3:0]                 flags_in,
  input  armdp_pkg::op_t             op,
  input  logic                       upd,
  input  logic                       form_ok,
  output armdp_pkg::alu_res_t        out
);

  logic                       is_sub;
  logic [armdp_pkg::XLEN-1:0] b;
  logic [32:0]                sum;
  logic [armdp_pkg::XLEN-1:0] r;
  logic                       c_add;
  logic                       v_add;
  logic [armdp_pkg::XLEN-1:0] lres;
  logic [3:0]                 arith_flags;
  logic [3:0]                 logic_flags;

  assign is_sub = (op == armdp_pkg::OP_SUB) || (op == armdp_pkg::OP_CMP);
  assign b      = is_sub ? ~op2 : op2;
  assign sum    = {1'b0, a} + {1'b0, b} + {32'd0, is_sub};
  assign r      = sum[31:0];
  assign c_add  = sum[32];
  assign v_add  = (a[31] ^ r[31]) & (b[31] ^ r[31]);

  assign arith_flags = {r[31], r == '0, c_add, v_add};

  always_comb begin
    lres = op2;
    unique case (op)
      armdp_pkg::OP_AND: lres = a & op2;
      armdp_pkg::OP_EOR: lres = a ^ op2;
      armdp_pkg::OP_BIC: lres = a & ~op2;
      armdp_pkg::OP_MVN: lres = ~op2;
      default:           lres = op2;
    endcase
  end

  // logical ops keep V
  assign logic_flags = {lres[31], lres == '0, sc, flags_in[armdp_pkg::FLAG_V]};

  always_comb begin
    out.wr    = 1'b0;
    out.unsup = 1'b0;
    out.res   = '0;
    out.flags = flags_in;
    if (!form_ok) begin
      out.unsup = 1'b1;
    end else begin
      unique case (op)
        armdp_pkg::OP_AND, armdp_pkg::OP_EOR, armdp_pkg::OP_MOV,
        armdp_pkg::OP_BIC, armdp_pkg::OP_MVN: begin
          out.wr  = 1'b1;
          out.res = lres;
          if (upd) out.flags = logic_flags;
        end
        armdp_pkg::OP_ADD, armdp_pkg::OP_SUB: begin
          out.wr  = 1'b1;
          out.res = r;
          if (upd) out.flags = arith_flags;
        end
        armdp_pkg::OP_CMP: begin
          out.flags = arith_flags;
        end
        default: begin
          out.unsup = 1'b1;
        end
      endcase
    end
  end

endmodule

// ===== src/arm_data_processing_execute.sv =====
// ARM data-processing execute stage: input register, operand shifter, ALU, result register.
// The accepted item waits in the input register; the shifter and ALU work on it between the
// registers, and the result register loads it once the result side is free or being drained.
// Throughput: one item per cycle while the output is not stalled; the register file and flags
// are written at the same edge as the result register, so the next item sees them without a bubble.
// Reset (rst_n low, synchronous): both stages empty, register file and NZCV cleared.
module arm_data_processing_execute (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] instruction
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [3:0] dest_index, [35:4] write_value,
                                  // [36] write_enable, [40:37] flags_out, [47:41] zero
  output logic        out_tuser   // [0] unsupported
);

  localparam int unsigned XLEN = armdp_pkg::XLEN;

  logic                in_vld_r;
  armdp_pkg::cmd_t     in_cmd_r;
  logic [31:0]         in_inst_r;

  logic [XLEN-1:0]     rf_r [armdp_pkg::NREGS];
  logic [3:0]          flags_r;

  logic                out_vld_r;
  logic [3:0]          out_dest_r;
  logic [XLEN-1:0]     out_val_r;
  logic                out_we_r;
  logic [3:0]          out_flags_r;
  logic                out_unsup_r;

  logic                fire;

  armdp_pkg::op_t      op;
  logic                s_bit;
  logic [3:0]          rn, rd, rs, rm;
  logic [4:0]          imm5;
  logic [1:0]          sh_type;
  logic                upd;

  logic [XLEN-1:0]     sh_val;
  armdp_pkg::shift_t   sh_kind;
  logic [7:0]          sh_amt;
  logic                form_ok;
  logic [XLEN-1:0]     op2;
  logic                sc;
  armdp_pkg::alu_res_t alu_out;

  assign fire      = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || fire;

  // Field decode
  assign op      = armdp_pkg::op_t'(in_inst_r[24:21]);
  assign s_bit   = in_inst_r[20];
  assign rn      = in_inst_r[19:16];
  assign rd      = in_inst_r[15:12];
  assign rs      = in_inst_r[11:8];
  assign imm5    = in_inst_r[11:7];
  assign sh_type = in_inst_r[6:5];
  assign rm      = in_inst_r[3:0];
  assign upd     = s_bit && (rd != armdp_pkg::PC_INDEX);

  // Operand-2 selection feeding the shared shifter
  always_comb begin
    sh_val  = rf_r[rm];
    sh_kind = armdp_pkg::shift_t'({1'b0, sh_type});
    sh_amt  = {3'd0, imm5};
    form_ok = 1'b1;
    unique case (in_cmd_r)
      armdp_pkg::CMD_REG: begin
        if ((sh_kind == armdp_pkg::SH_LSR || sh_kind == armdp_pkg::SH_ASR) &&
            imm5 == 5'd0) begin
          sh_amt = 8'd32;
        end else if (sh_kind == armdp_pkg::SH_ROR && imm5 == 5'd0) begin
          sh_kind = armdp_pkg::SH_RRX;
          sh_amt  = 8'd1;
        end
      end
      armdp_pkg::CMD_IMM: begin
        // 8-bit immediate rotated right by twice the 4-bit field
        sh_val  = {24'd0, in_inst_r[7:0] & armdp_pkg::IMM8_MASK};
        sh_kind = armdp_pkg::SH_ROR;
        sh_amt  = {3'd0, in_inst_r[11:8], 1'b0};
      end
      armdp_pkg::CMD_RSR: begin
        sh_amt  = rf_r[rs][7:0];
        form_ok = (op == armdp_pkg::OP_ADD);
      end
      default: begin
        form_ok = 1'b0;
      end
    endcase
  end

  armdp_shifter u_shifter (
    .value (sh_val),
    .kind  (sh_kind),
    .amt   (sh_amt),
    .cin   (flags_r[armdp_pkg::FLAG_C]),
    .res   (op2),
    .cout  (sc)
  );

  armdp_alu u_alu (
    .a        (rf_r[rn]),
    .op2      (op2),
    .sc       (sc),
    .flags_in (flags_r),
    .op       (op),
    .upd      (upd),
    .form_ok  (form_ok),
    .out      (alu_out)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      in_cmd_r  <= armdp_pkg::cmd_t'(in_tuser);
      in_inst_r <= in_tdata;
    end
  end

  // Architectural state, committed with the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < armdp_pkg::NREGS; i++) begin
        rf_r[i] <= '0;
      end
      flags_r <= '0;
    end else if (fire && !alu_out.unsup) begin
      flags_r <= alu_out.flags;
      if (alu_out.wr) rf_r[rd] <= alu_out.res;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
    if (fire) begin
      out_dest_r  <= alu_out.wr ? rd : 4'd0;
      out_val_r   <= alu_out.res;
      out_we_r    <= alu_out.wr;
      out_flags_r <= alu_out.flags;
      out_unsup_r <= alu_out.unsup;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'd0, out_flags_r, out_we_r, out_val_r, out_dest_r};
  assign out_tuser  = out_unsup_r;

endmodule

// ===== src/armdp_checker.sv =====
// Port-level checker for the execute block, bound to the top level.
module armdp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic        out_tuser
);

  // unsupported items report no register write
  a_unsup_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[36] == 1'b0))
    else $error("unsupported item reports a register write");

  // without a write, destination and value read as zero
  a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[36]) |-> (out_tdata[35:0] == 36'd0))
    else $error("non-writing item carries a destination or value");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[47:41] == 7'd0))
    else $error("result padding bits not zero");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result changed");

  // with the result side empty there is always room for an item
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with no result pending");

endmodule

bind arm_data_processing_execute armdp_checker u_armdp_checker (.*);
